@@ design/ktl_pkg.sv @@
package ktl_pkg;

  localparam int unsigned MaxKeys  = 64;
  localparam int unsigned IdxW     = (MaxKeys > 1) ? $clog2(MaxKeys) : 1;
  localparam int unsigned CntW     = $clog2(MaxKeys + 1);
  localparam int unsigned CapW     = 7;
  localparam int unsigned TimeW    = 32;
  localparam int unsigned HandleW  = 32;
  localparam int unsigned CmdW     = 3;
  localparam int unsigned StatusW  = 3;

  // APB register map
  localparam int unsigned ApbAddrW  = 3;
  localparam int unsigned ApbDataW  = 32;
  localparam int unsigned RegIdxW   = ApbAddrW - 2;
  localparam logic [RegIdxW-1:0] RegKeyCapacity = '0;
  localparam logic [CapW-1:0]    CapReset       = CapW'(MaxKeys);

  typedef enum logic [CmdW-1:0] {
    CmdAppend = 3'd0,
    CmdRemove = 3'd1,
    CmdClear  = 3'd2,
    CmdLookup = 3'd3,
    CmdRead   = 3'd4
  } cmd_e;

  typedef enum logic [StatusW-1:0] {
    StOk    = 3'd0,
    StFull  = 3'd1,
    StMiss  = 3'd2,
    StOrder = 3'd3,
    StRange = 3'd4
  } status_e;

  typedef struct packed {
    logic               we;
    logic [IdxW-1:0]    waddr;
    logic [TimeW-1:0]   wtime;
    logic [HandleW-1:0] whandle;
    logic [IdxW-1:0]    taddr;
    logic [IdxW-1:0]    haddr;
  } mem_req_t;

  typedef struct packed {
    status_e            status;
    logic [IdxW-1:0]    found_index;
    logic [HandleW-1:0] found_handle;
    logic [CntW-1:0]    key_count;
    logic [TimeW-1:0]   total_length;
  } result_t;

endpackage

@@ design/ktl_key_store.sv @@
module ktl_key_store (
  input  logic                         clk_i,
  input  ktl_pkg::mem_req_t            mem_req_i,
  output logic [ktl_pkg::TimeW-1:0]    tdata_o,
  output logic [ktl_pkg::HandleW-1:0]  hdata_o
);

  logic [ktl_pkg::TimeW-1:0]   time_mem   [ktl_pkg::MaxKeys];
  logic [ktl_pkg::HandleW-1:0] handle_mem [ktl_pkg::MaxKeys];
  logic [ktl_pkg::TimeW-1:0]   tdata_q;
  logic [ktl_pkg::HandleW-1:0] hdata_q;

  // one write port, one registered read port per array
  always_ff @(posedge clk_i) begin
    if (mem_req_i.we) begin
      time_mem[mem_req_i.waddr]   <= mem_req_i.wtime;
      handle_mem[mem_req_i.waddr] <= mem_req_i.whandle;
    end
    tdata_q <= time_mem[mem_req_i.taddr];
    hdata_q <= handle_mem[mem_req_i.haddr];
  end

  assign tdata_o = tdata_q;
  assign hdata_o = hdata_q;

endmodule

@@ design/ktl_seq.sv @@
module ktl_seq (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [ktl_pkg::CmdW-1:0]      command_i,
  input  logic [ktl_pkg::TimeW-1:0]     time_value_i,
  input  logic [ktl_pkg::HandleW-1:0]   data_handle_i,
  input  logic [ktl_pkg::IdxW-1:0]      read_index_i,
  input  logic [ktl_pkg::CapW-1:0]      key_capacity_i,
  input  logic                          out_free_i,
  output logic                          out_load_o,
  output ktl_pkg::result_t              result_o,
  output ktl_pkg::mem_req_t             mem_req_o,
  input  logic [ktl_pkg::TimeW-1:0]     tdata_i,
  input  logic [ktl_pkg::HandleW-1:0]   hdata_i
);

  localparam int unsigned IdxW = ktl_pkg::IdxW;
  localparam int unsigned CntW = ktl_pkg::CntW;

  typedef enum logic [2:0] {
    Idle,
    Search,
    Final,
    RdWait,
    RmWait,
    Resp
  } state_e;

  state_e                        state_q, state_d;
  logic [CntW-1:0]               count_q, count_d;
  logic [ktl_pkg::TimeW-1:0]     last_q, last_d;
  logic [ktl_pkg::TimeW-1:0]     time_q, time_d;
  logic [IdxW-1:0]               lo_q, lo_d;
  logic [IdxW-1:0]               hi_q, hi_d;
  logic [IdxW-1:0]               mid_q, mid_d;
  ktl_pkg::status_e              status_q, status_d;
  logic [IdxW-1:0]               fidx_q, fidx_d;
  logic [ktl_pkg::HandleW-1:0]   fhandle_q, fhandle_d;

  logic [CntW-1:0]               eff_cap;
  logic [IdxW-1:0]               lo_n, hi_n;
  logic [IdxW:0]                 mid_sum;

  assign eff_cap = (CntW'(key_capacity_i) < CntW'(ktl_pkg::MaxKeys)) ?
                   CntW'(key_capacity_i) : CntW'(ktl_pkg::MaxKeys);

  // bisection step on the timestamp just read back
  always_comb begin
    lo_n = lo_q;
    hi_n = hi_q;
    if (time_q > tdata_i) begin
      lo_n = mid_q + 1'b1;
    end else begin
      hi_n = mid_q;
    end
    mid_sum = {1'b0, lo_n} + {1'b0, hi_n};
  end

  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    last_d     = last_q;
    time_d     = time_q;
    lo_d       = lo_q;
    hi_d       = hi_q;
    mid_d      = mid_q;
    status_d   = status_q;
    fidx_d     = fidx_q;
    fhandle_d  = fhandle_q;
    mem_req_o  = '0;
    out_load_o = 1'b0;

    unique case (state_q)
      Idle: begin
        if (in_valid_i) begin
          time_d    = time_value_i;
          status_d  = ktl_pkg::StOk;
          fidx_d    = '0;
          fhandle_d = '0;
          state_d   = Resp;
          unique case (ktl_pkg::cmd_e'(command_i))
            ktl_pkg::CmdAppend: begin
              if (count_q != '0 && time_value_i <= last_q) begin
                status_d = ktl_pkg::StOrder;
              end else if (count_q >= eff_cap) begin
                status_d = ktl_pkg::StFull;
              end else begin
                mem_req_o.we      = 1'b1;
                mem_req_o.waddr   = IdxW'(count_q);
                mem_req_o.wtime   = time_value_i;
                mem_req_o.whandle = data_handle_i;
                count_d           = count_q + 1'b1;
                last_d            = time_value_i;
              end
            end
            ktl_pkg::CmdRemove: begin
              if (count_q == '0) begin
                status_d = ktl_pkg::StMiss;
              end else begin
                count_d = count_q - 1'b1;
                if (count_q == CntW'(1)) begin
                  last_d = '0;
                end else begin
                  // fetch the new last timestamp
                  mem_req_o.taddr = IdxW'(count_q - CntW'(2));
                  state_d         = RmWait;
                end
              end
            end
            ktl_pkg::CmdClear: begin
              count_d = '0;
              last_d  = '0;
            end
            ktl_pkg::CmdLookup: begin
              if (count_q == '0) begin
                status_d = ktl_pkg::StMiss;
              end else begin
                lo_d = '0;
                hi_d = IdxW'(count_q - 1'b1);
                if (hi_d != '0) begin
                  mid_d           = hi_d >> 1;
                  mem_req_o.taddr = mid_d;
                  state_d         = Search;
                end else begin
                  mem_req_o.taddr = '0;
                  state_d         = Final;
                end
              end
            end
            ktl_pkg::CmdRead: begin
              if (CntW'(read_index_i) >= count_q) begin
                status_d = ktl_pkg::StRange;
              end else begin
                mem_req_o.haddr = read_index_i;
                state_d         = RdWait;
              end
            end
            default: begin
            end
          endcase
        end
      end
      Search: begin
        lo_d = lo_n;
        hi_d = hi_n;
        if (lo_n < hi_n) begin
          mid_d           = mid_sum[IdxW:1];
          mem_req_o.taddr = mid_sum[IdxW:1];
        end else begin
          mem_req_o.taddr = lo_n;
          state_d         = Final;
        end
      end
      Final: begin
        if (tdata_i < time_q) begin
          status_d = ktl_pkg::StMiss;
        end else begin
          fidx_d = lo_q;
        end
        state_d = Resp;
      end
      RdWait: begin
        fhandle_d = hdata_i;
        state_d   = Resp;
      end
      RmWait: begin
        last_d  = tdata_i;
        state_d = Resp;
      end
      Resp: begin
        if (out_free_i) begin
          out_load_o = 1'b1;
          state_d    = Idle;
        end
      end
      default: begin
        state_d = Idle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= Idle;
      count_q   <= '0;
      last_q    <= '0;
      time_q    <= '0;
      lo_q      <= '0;
      hi_q      <= '0;
      mid_q     <= '0;
      status_q  <= ktl_pkg::StOk;
      fidx_q    <= '0;
      fhandle_q <= '0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      last_q    <= last_d;
      time_q    <= time_d;
      lo_q      <= lo_d;
      hi_q      <= hi_d;
      mid_q     <= mid_d;
      status_q  <= status_d;
      fidx_q    <= fidx_d;
      fhandle_q <= fhandle_d;
    end
  end

  assign in_stall_o = (state_q != Idle);

  always_comb begin
    result_o.status       = status_q;
    result_o.found_index  = fidx_q;
    result_o.found_handle = fhandle_q;
    result_o.key_count    = count_q;
    result_o.total_length = last_q;
  end

endmodule

@@ design/keyframe_time_lookup_table_core.sv @@
// Keyframe time table: an append-only list of animation keys (16.16 timestamp
// plus a 32-bit data handle) held in a 64-entry synchronous memory.
// Input channel: one transaction per command (append, remove last, clear,
// lookup, read), qualified by in_valid_i / in_stall_o. Output channel: one
// result transaction per command, qualified by out_valid_o / out_stall_i.
// key_capacity is written over the APB port at byte address 0, by the user
// only while idle; the block itself does not enforce it.
// Append, remove on one key, clear and rejected commands go straight to the
// response state; remove (new last key fetched from memory) and read wait
// for one memory read first; lookup runs its bisection probes through the
// memory read port, one per cycle, then checks the key found. One command
// is in flight at a time; a finished result sits in the output register, so
// the next command is taken while it waits.
// Reset empties the table (count and total length zero) and sets the
// capacity to 64; memory contents are not cleared, nor need to be.
// A stalled receiver holds the result; a second finished result then waits
// inside the sequencer and the input stalls.
module keyframe_time_lookup_table_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // command channel
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [ktl_pkg::CmdW-1:0]          command_i,
  input  logic [ktl_pkg::TimeW-1:0]         time_value_i,
  input  logic [ktl_pkg::HandleW-1:0]       data_handle_i,
  input  logic [ktl_pkg::IdxW-1:0]          read_index_i,
  // result channel
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [ktl_pkg::StatusW-1:0]       status_o,
  output logic [ktl_pkg::IdxW-1:0]          found_index_o,
  output logic [ktl_pkg::HandleW-1:0]       found_handle_o,
  output logic [ktl_pkg::CntW-1:0]          key_count_o,
  output logic [ktl_pkg::TimeW-1:0]         total_length_o,
  // APB register port
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [ktl_pkg::ApbAddrW-1:0]      paddr,
  input  logic [ktl_pkg::ApbDataW-1:0]      pwdata,
  output logic [ktl_pkg::ApbDataW-1:0]      prdata,
  output logic                              pready
);

  logic [ktl_pkg::CapW-1:0]     cap_q;
  logic [ktl_pkg::RegIdxW-1:0]  reg_idx;
  logic                         cfg_wr;

  ktl_pkg::mem_req_t            mem_req;
  logic [ktl_pkg::TimeW-1:0]    tdata;
  logic [ktl_pkg::HandleW-1:0]  hdata;

  ktl_pkg::result_t             seq_res;
  logic                         out_load;
  logic                         out_free;
  logic                         out_valid_q;
  ktl_pkg::result_t             out_res_q;

  // ---- register port: word address selects the register ----
  assign reg_idx = paddr[ktl_pkg::ApbAddrW-1:2];
  assign cfg_wr  = psel && penable && pwrite && (reg_idx == ktl_pkg::RegKeyCapacity);
  assign pready  = 1'b1;
  assign prdata  = (reg_idx == ktl_pkg::RegKeyCapacity) ?
                   ktl_pkg::ApbDataW'(cap_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= ktl_pkg::CapReset;
    end else if (cfg_wr) begin
      cap_q <= pwdata[ktl_pkg::CapW-1:0];
    end
  end

  // ---- key memory ----
  ktl_key_store u_key_store (
    .clk_i     (clk_i),
    .mem_req_i (mem_req),
    .tdata_o   (tdata),
    .hdata_o   (hdata)
  );

  // ---- command sequencer ----
  ktl_seq u_seq (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .command_i      (command_i),
    .time_value_i   (time_value_i),
    .data_handle_i  (data_handle_i),
    .read_index_i   (read_index_i),
    .key_capacity_i (cap_q),
    .out_free_i     (out_free),
    .out_load_o     (out_load),
    .result_o       (seq_res),
    .mem_req_o      (mem_req),
    .tdata_i        (tdata),
    .hdata_i        (hdata)
  );

  // ---- output register: frees the sequencer while the receiver stalls ----
  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_res_q <= seq_res;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = out_res_q.status;
  assign found_index_o  = out_res_q.found_index;
  assign found_handle_o = out_res_q.found_handle;
  assign key_count_o    = out_res_q.key_count;
  assign total_length_o = out_res_q.total_length;

endmodule

@@ design/ktl_checker.sv @@
module ktl_checker (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  input  logic                              in_stall_o,
  input  logic [ktl_pkg::CmdW-1:0]          command_i,
  input  logic [ktl_pkg::TimeW-1:0]         time_value_i,
  input  logic [ktl_pkg::HandleW-1:0]       data_handle_i,
  input  logic [ktl_pkg::IdxW-1:0]          read_index_i,
  input  logic                              out_valid_o,
  input  logic                              out_stall_i,
  input  logic [ktl_pkg::StatusW-1:0]       status_o,
  input  logic [ktl_pkg::IdxW-1:0]          found_index_o,
  input  logic [ktl_pkg::HandleW-1:0]       found_handle_o,
  input  logic [ktl_pkg::CntW-1:0]          key_count_o,
  input  logic [ktl_pkg::TimeW-1:0]         total_length_o,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [ktl_pkg::ApbAddrW-1:0]      paddr,
  input  logic [ktl_pkg::ApbDataW-1:0]      pwdata,
  input  logic [ktl_pkg::ApbDataW-1:0]      prdata,
  input  logic                              pready
);

  // result held while the receiver stalls
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(status_o) &&
    $stable(key_count_o) && $stable(total_length_o))
    else $error("result changed under stall");

  // one command in flight: the input stalls right after a transaction
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("second command taken while busy");

  // failed commands report no index and no handle
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != ktl_pkg::StOk |->
    found_index_o == '0 && found_handle_o == '0)
    else $error("nonzero index or handle on failure");

  // table never exceeds its storage; empty table has zero length
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> key_count_o <= ktl_pkg::CntW'(ktl_pkg::MaxKeys) &&
    (key_count_o != '0 || total_length_o == '0))
    else $error("key count or total length inconsistent");

endmodule

bind keyframe_time_lookup_table_core ktl_checker u_ktl_checker (.*);

@@ test/keyframe_scoreboard_pkg.sv @@
`timescale 1ns / 1ps

package ktl_tb_pkg;

  import ktl_pkg::*;

  class keyframe_scoreboard;

    // Shadow copy of the key table
    logic [TimeW-1:0]   key_times   [MaxKeys];
    logic [HandleW-1:0] key_handles [MaxKeys];
    int unsigned        stored_keys;
    int unsigned        capacity;

    result_t            pending_results [$];
    int unsigned        mismatches;

    function new();
      stored_keys = 0;
      capacity    = CapReset;
      mismatches  = 0;
    endfunction

    function void set_capacity(logic [CapW-1:0] value);
      capacity = value;
    endfunction

    function logic [TimeW-1:0] last_time();
      return (stored_keys == 0) ? '0 : key_times[stored_keys-1];
    endfunction

    function void report(string msg);
      mismatches++;
      $display("mismatch: %s", msg);
    endfunction

    // Apply one accepted command to the shadow table, queue the expected result.
    function void note_command(logic [CmdW-1:0] cmd, logic [TimeW-1:0] t,
                               logic [HandleW-1:0] h, logic [IdxW-1:0] ri);
      result_t     exp;
      int unsigned limit;
      int          hit;
      exp.status       = StOk;
      exp.found_index  = '0;
      exp.found_handle = '0;
      limit = (capacity < MaxKeys) ? capacity : MaxKeys;
      case (cmd)
        CmdAppend: begin
          // order check wins over the full check
          if (stored_keys != 0 && t <= last_time()) begin
            exp.status = StOrder;
          end else if (stored_keys >= limit) begin
            exp.status = StFull;
          end else begin
            key_times[stored_keys]   = t;
            key_handles[stored_keys] = h;
            stored_keys++;
          end
        end
        CmdRemove: begin
          if (stored_keys == 0) exp.status = StMiss;
          else stored_keys--;
        end
        CmdClear: begin
          stored_keys = 0;
        end
        CmdLookup: begin
          // keys are strictly increasing, so the first key at or after t
          hit = -1;
          for (int i = 0; i < stored_keys; i++) begin
            if (hit < 0 && key_times[i] >= t) hit = i;
          end
          if (hit < 0) exp.status = StMiss;
          else exp.found_index = IdxW'(hit);
        end
        CmdRead: begin
          if (ri >= stored_keys) exp.status = StRange;
          else exp.found_handle = key_handles[ri];
        end
        default: ;
      endcase
      exp.key_count    = CntW'(stored_keys);
      exp.total_length = last_time();
      pending_results.push_back(exp);
    endfunction

    function void check_result(logic [StatusW-1:0] status, logic [IdxW-1:0] idx,
                               logic [HandleW-1:0] handle, logic [CntW-1:0] count,
                               logic [TimeW-1:0] total);
      result_t exp;
      if (pending_results.size() == 0) begin
        report("result transaction with no command pending");
        return;
      end
      exp = pending_results.pop_front();
      if (status !== exp.status)
        report($sformatf("status got %0d want %0d", status, exp.status));
      if (idx !== exp.found_index)
        report($sformatf("found_index got %0d want %0d", idx, exp.found_index));
      if (handle !== exp.found_handle)
        report($sformatf("found_handle got %h want %h", handle, exp.found_handle));
      if (count !== exp.key_count)
        report($sformatf("key_count got %0d want %0d", count, exp.key_count));
      if (total !== exp.total_length)
        report($sformatf("total_length got %h want %h", total, exp.total_length));
    endfunction

  endclass

endpackage

@@ test/testbench.sv @@
`timescale 1ns / 1ps

module testbench;

  import ktl_pkg::*;
  import ktl_tb_pkg::*;

  localparam int ClkHalf   = 4;
  localparam int IdleLimit = 2000;   // cycles without any transaction
  localparam int HoldOff   = 16;     // settle time after the last result

  // Random phases: capacity setting and number of commands in each
  localparam int NumPhases = 7;
  localparam int PhaseCap   [NumPhases] = '{64, 5, 0, 64, 33, 1, 64};
  localparam int PhaseItems [NumPhases] = '{300, 100, 60, 250, 150, 60, 100};

  logic                 clk_i;
  logic                 rst_ni;
  logic                 in_valid_i;
  logic                 in_stall_o;
  logic [CmdW-1:0]      command_i;
  logic [TimeW-1:0]     time_value_i;
  logic [HandleW-1:0]   data_handle_i;
  logic [IdxW-1:0]      read_index_i;
  logic                 out_valid_o;
  logic                 out_stall_i;
  logic [StatusW-1:0]   status_o;
  logic [IdxW-1:0]      found_index_o;
  logic [HandleW-1:0]   found_handle_o;
  logic [CntW-1:0]      key_count_o;
  logic [TimeW-1:0]     total_length_o;
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [ApbAddrW-1:0]  paddr;
  logic [ApbDataW-1:0]  pwdata;
  logic [ApbDataW-1:0]  prdata;
  logic                 pready;

  keyframe_scoreboard sb;
  int unsigned        idle_cycles;
  int unsigned        send_quiet;    // remaining commands sent back to back
  int unsigned        stall_quiet;   // remaining cycles without receiver stall

  keyframe_time_lookup_table_core dut (.*);

  always #(ClkHalf) clk_i = ~clk_i;

  // Idle length: mostly short, now and then a long one.
  function automatic int unsigned pick_idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  task automatic wait_results_drained();
    while (sb.pending_results.size() != 0) @(posedge clk_i);
  endtask

  // Command channel driver. Inputs move at the falling edge; the transaction
  // is taken at the first rising edge with the stall low. Valid is lowered
  // only when a gap follows, so it is never dropped and raised in one step.
  task automatic send_command(input logic [CmdW-1:0] cmd, input logic [TimeW-1:0] t,
                              input logic [HandleW-1:0] h, input logic [IdxW-1:0] ri);
    int unsigned gap;
    bit          pause;
    if (send_quiet != 0) begin
      send_quiet--;
      gap = 0;
    end else begin
      gap = pick_idle_len();
      if ($urandom_range(0, 49) == 0) send_quiet = $urandom_range(20, 60);
    end
    // occasionally hold off until the block has delivered everything
    pause = ($urandom_range(0, 149) == 0);
    if (pause && gap == 0) gap = 1;
    if (gap != 0) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      if (pause) wait_results_drained();
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i    <= 1'b1;
    command_i     <= cmd;
    time_value_i  <= t;
    data_handle_i <= h;
    read_index_i  <= ri;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_command(cmd, t, h, ri);
  endtask

  // Capacity write over APB, only with the block idle, then read back.
  task automatic write_capacity(input logic [CapW-1:0] value);
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    wait_results_drained();
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {RegKeyCapacity, 2'b00};
    pwdata  <= ApbDataW'(value);
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    sb.set_capacity(value);
    // back-to-back read of the same register
    @(negedge clk_i);
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata[CapW-1:0] !== value)
      sb.report($sformatf("key_capacity read %0d want %0d", prdata[CapW-1:0], value));
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // One random command, mostly well formed against the current table:
  // increasing appends, lookups near stored keys, reads near the count.
  task automatic send_random_command();
    int unsigned      r;
    int unsigned      k;
    int unsigned      n;
    logic [CmdW-1:0]  cmd;
    logic [TimeW-1:0] t;
    logic [TimeW-1:0] base;
    logic [HandleW-1:0] h;
    logic [IdxW-1:0]  ri;
    n    = sb.stored_keys;
    base = sb.last_time();
    t    = $urandom;
    h    = $urandom;
    ri   = IdxW'($urandom);
    r    = $urandom_range(0, 99);
    if (r < 42) begin
      cmd = CmdAppend;
      if (n != 0) begin
        k = $urandom_range(0, 99);
        if (k < 6)       t = base;                                // equal time
        else if (k < 10) t = base - $urandom_range(1, 4096);      // going back
        else if (k < 18) t = base + 1;
        else if (k < 75) t = base + $urandom_range(1, 1 << 18);
        else if (k < 95) t = base + $urandom_range(1, 1 << 26);
        else             t = base + $urandom;
      end else if ($urandom_range(0, 1) == 0) begin
        t = $urandom_range(0, 1 << 16);
      end
    end else if (r < 64) begin
      cmd = CmdLookup;
      if (n != 0) begin
        k = $urandom_range(0, n - 1);
        case ($urandom_range(0, 5))
          0: t = sb.key_times[k];
          1: t = sb.key_times[k] - 1;
          2: t = sb.key_times[k] + 1;
          3: t = base + 1;                // just past the last key
          4: t = sb.key_times[0];
          default: ;
        endcase
      end
    end else if (r < 79) begin
      cmd = CmdRead;
      if (n != 0) ri = IdxW'($urandom_range(0, (n > 63) ? 63 : n));
    end else if (r < 88) begin
      cmd = CmdRemove;
    end else if (r < 90) begin
      cmd = CmdClear;
    end else if (r < 93) begin
      cmd = CmdW'($urandom_range(5, 7));  // unused codes
    end else begin
      cmd = CmdW'($urandom);              // noise over every field
    end
    send_command(cmd, t, h, ri);
  endtask

  // Receiver: stall-free runs broken by stalls of random length.
  initial begin
    int unsigned run;
    int unsigned stall;
    out_stall_i = 1'b0;
    forever begin
      run = $urandom_range(1, 6);
      repeat (run) @(negedge clk_i);
      if (stall_quiet != 0) begin
        stall_quiet = (stall_quiet > run) ? stall_quiet - run : 0;
        stall = 0;
      end else begin
        stall = pick_idle_len();
        if ($urandom_range(0, 29) == 0) stall_quiet = $urandom_range(40, 200);
      end
      if (stall != 0) begin
        @(negedge clk_i);
        out_stall_i <= 1'b1;
        repeat (stall - 1) @(negedge clk_i);
        @(negedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  // Result monitor and watchdog: results are checked at the rising edge;
  // a long stretch with no transaction on either channel ends the run.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      sb.check_result(status_o, found_index_o, found_handle_o, key_count_o,
                      total_length_o);
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    sb            = new();
    clk_i         = 1'b0;
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    command_i     = '0;
    time_value_i  = '0;
    data_handle_i = '0;
    read_index_i  = '0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    idle_cycles   = 0;
    send_quiet    = 0;
    stall_quiet   = 0;

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: empty table behavior, edge timestamps, every command.
    write_capacity(CapW'(64));
    send_command(CmdLookup, 32'h0, 32'h0, '0);          // lookup on empty
    send_command(CmdRemove, 32'h0, 32'h0, '0);          // remove on empty
    send_command(CmdRead,   32'h0, 32'h0, '0);          // read on empty
    send_command(CmdAppend, 32'h0, 32'h0, '0);          // time zero is fine first
    send_command(CmdAppend, 32'h0, 32'h1, '0);          // equal time: order error
    send_command(CmdAppend, 32'h00FF_0000, 32'hFFFF_FFFF, '0);
    send_command(CmdAppend, 32'hFF00_0000, 32'h5A5A_5A5A, '0);
    send_command(CmdLookup, 32'h0, 32'h0, '0);
    send_command(CmdLookup, 32'h1, 32'h0, '0);
    send_command(CmdLookup, 32'hFF00_0000, 32'h0, '0);
    send_command(CmdLookup, 32'hFF00_0001, 32'h0, '0); // past the last key
    send_command(CmdRead,   32'h0, 32'h0, IdxW'(2));
    send_command(CmdRead,   32'h0, 32'h0, IdxW'(3));    // index at count
    send_command(CmdRead,   32'h0, 32'h0, '1);          // top index
    send_command(CmdW'(5), $urandom, $urandom, IdxW'($urandom));
    send_command(CmdW'(6), $urandom, $urandom, IdxW'($urandom));
    send_command(CmdW'(7), '1, '1, '1);
    send_command(CmdRemove, 32'h0, 32'h0, '0);
    send_command(CmdAppend, 32'hFFFF_FFFF, 32'h1234_5678, '0);
    send_command(CmdLookup, 32'hFFFF_FFFF, 32'h0, '0);
    send_command(CmdClear,  32'h0, 32'h0, '0);
    send_command(CmdLookup, 32'hFFFF_FFFF, 32'h0, '0);

    // Capacity limits, including a limit below the current count.
    write_capacity(CapW'(2));
    send_command(CmdAppend, 32'd10, 32'hA, '0);
    send_command(CmdAppend, 32'd20, 32'hB, '0);
    send_command(CmdAppend, 32'd30, 32'hC, '0);         // full
    send_command(CmdAppend, 32'd5,  32'hD, '0);         // order beats full
    write_capacity(CapW'(1));
    send_command(CmdAppend, 32'd40, 32'hE, '0);         // count above limit
    write_capacity(CapW'(0));
    send_command(CmdAppend, 32'd50, 32'hF, '0);
    send_command(CmdRead,   32'h0, 32'h0, IdxW'(1));    // stored keys kept

    // Random phases; the table carries over from phase to phase.
    for (int p = 0; p < NumPhases; p++) begin
      write_capacity(CapW'(PhaseCap[p]));
      repeat (PhaseItems[p]) send_random_command();
    end

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    wait_results_drained();
    repeat (HoldOff) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.pending_results.size() == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
